/* rtl/crc32w_pkg.sv */
package crc32w_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned CrcW  = 32;

  localparam logic [CrcW-1:0] CrcAllOnes = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] CrcPoly    = 32'hEDB8_8320;

  // one registered request on its way to the crc core
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
    logic             last;
  } crc32w_item_t;

  // fold one word into the remainder: high byte first, each byte lsb first
  function automatic logic [CrcW-1:0] fold_word(input logic [CrcW-1:0]  rem,
                                                input logic [WordW-1:0] word);
    logic [CrcW-1:0] acc;
    logic [7:0]      octet;
    acc = rem;
    for (int b = 0; b < 2; b++) begin
      octet = (b == 0) ? word[15:8] : word[7:0];
      acc[7:0] = acc[7:0] ^ octet;
      for (int k = 0; k < 8; k++) begin
        acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
      end
    end
    return acc;
  endfunction

endpackage

/* rtl/crc32w_in_stage.sv */
module crc32w_in_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [crc32w_pkg::WordW-1:0]    word,
  input  logic                            last,
  input  logic                            go,
  output crc32w_pkg::crc32w_item_t        item
);

  crc32w_pkg::crc32w_item_t item_next;
  logic                     take;

  // stall only while a held request cannot move on
  assign in_stall = item.valid & ~go;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    item_next = item;
    if (take) begin
      item_next.valid = 1'b1;
      item_next.word  = word;
      item_next.last  = last;
    end else if (go) begin
      item_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= item_next.valid;
    end
    item.word <= item_next.word;
    item.last <= item_next.last;
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item.valid)
    else $error("stall raised with empty input register");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (item.valid && !go) |=> item.valid && $stable(item.word) && $stable(item.last))
    else $error("blocked request changed");

  a_go_needs_item: assert property (@(posedge clk) disable iff (rst)
    go |-> item.valid)
    else $error("advance without a request");

endmodule

/* rtl/crc32w_core.sv */
module crc32w_core (
  input  logic                          clk,
  input  logic                          rst,
  input  crc32w_pkg::crc32w_item_t      item,
  output logic                          go,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [crc32w_pkg::CrcW-1:0]   crc
);

  logic [crc32w_pkg::CrcW-1:0] remainder;
  logic [crc32w_pkg::CrcW-1:0] remainder_next;
  logic [crc32w_pkg::CrcW-1:0] folded;
  logic                        out_valid_next;
  logic                        finish;

  assign folded = crc32w_pkg::fold_word(remainder, item.word);

  // a non-last word never needs the result register
  assign go     = item.valid & (~item.last | ~out_valid | ~out_stall);
  assign finish = go & item.last;

  always_comb begin
    remainder_next = remainder;
    if (go) begin
      remainder_next = item.last ? crc32w_pkg::CrcAllOnes : folded;
    end
  end

  always_comb begin
    out_valid_next = out_valid & out_stall;
    if (finish) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= crc32w_pkg::CrcAllOnes;
      out_valid <= 1'b0;
    end else begin
      remainder <= remainder_next;
      out_valid <= out_valid_next;
    end
    if (finish) begin
      crc <= folded ^ crc32w_pkg::CrcAllOnes;
    end
  end

  a_rearm_after_last: assert property (@(posedge clk) disable iff (rst)
    finish |=> remainder == crc32w_pkg::CrcAllOnes)
    else $error("remainder not re-armed after last word");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(item.valid && item.last))
    else $error("result without a last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.last && out_valid && out_stall) |-> !go)
    else $error("pending result would be overwritten");

endmodule

/* rtl/crc32_over_16bit_words.sv */
// path: input register, then fold into the remainder; a last word loads the crc
// into the result register and raises out_valid once no stalled result is pending
// throughput: one word per cycle, the 16-step fold fits between two registers
// reset (rst, synchronous, active high): remainder re-armed to all ones,
// input and result registers emptied
module crc32_over_16bit_words (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [crc32w_pkg::WordW-1:0]  word,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [crc32w_pkg::CrcW-1:0]   crc
);

  // request held in the input register
  crc32w_pkg::crc32w_item_t item;
  // held request is folded this cycle
  logic                     go;

  // input register: parts the upstream handshake from the fold
  crc32w_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .word     (word),
    .last     (last),
    .go       (go),
    .item     (item)
  );

  // running remainder, fold logic and result register
  crc32w_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .go        (go),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .crc       (crc)
  );

endmodule
